[rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, constants and control store of the frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES  = 1024;
    localparam int FRAME_SHIFT = 12;
    localparam int ADDR_W      = 32;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int N_WORDS     = MAX_FRAMES / WORD_W;
    localparam int WORD_IDX_W  = $clog2(N_WORDS);
    localparam int CNT_W       = $clog2(MAX_FRAMES) + 1;
    localparam int HI_W        = CNT_W - BIT_W;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_END   = 1'd1;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam int UPC_W = 4;

    localparam logic [UPC_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] ST_DISPATCH = 4'd1;
    localparam logic [UPC_W-1:0] ST_ARD      = 4'd2;
    localparam logic [UPC_W-1:0] ST_ACHK     = 4'd3;
    localparam logic [UPC_W-1:0] ST_ANEXT    = 4'd4;
    localparam logic [UPC_W-1:0] ST_AFAIL    = 4'd5;
    localparam logic [UPC_W-1:0] ST_ASET     = 4'd6;
    localparam logic [UPC_W-1:0] ST_FCHK     = 4'd7;
    localparam logic [UPC_W-1:0] ST_FRD      = 4'd8;
    localparam logic [UPC_W-1:0] ST_FCLR     = 4'd9;
    localparam logic [UPC_W-1:0] ST_WAIT     = 4'd10;
    localparam logic [UPC_W-1:0] ST_EMIT     = 4'd11;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_SCAN,
        OP_NEXT,
        OP_FAIL,
        OP_SET,
        OP_FCHK,
        OP_CLR,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_NOIN,
        J_FREE,
        J_HIT,
        J_MORE,
        J_NOCLR,
        J_OUTBUSY
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic idle;
    } t_ctrl;

    typedef struct packed {
        logic hit;
        logic more;
        logic clr;
        logic out_busy;
    } t_stat;

    function automatic t_uword ucode(input logic [UPC_W-1:0] step);
        t_uword uw;
        case (step)
            ST_IDLE:     uw = '{OP_LOAD, J_NOIN,    ST_IDLE};
            ST_DISPATCH: uw = '{OP_NONE, J_FREE,    ST_FCHK};
            ST_ARD:      uw = '{OP_READ, J_NEXT,    ST_IDLE};
            ST_ACHK:     uw = '{OP_SCAN, J_HIT,     ST_ASET};
            ST_ANEXT:    uw = '{OP_NEXT, J_MORE,    ST_ARD};
            ST_AFAIL:    uw = '{OP_FAIL, J_ALWAYS,  ST_WAIT};
            ST_ASET:     uw = '{OP_SET,  J_ALWAYS,  ST_WAIT};
            ST_FCHK:     uw = '{OP_FCHK, J_NOCLR,   ST_WAIT};
            ST_FRD:      uw = '{OP_READ, J_NEXT,    ST_IDLE};
            ST_FCLR:     uw = '{OP_CLR,  J_NEXT,    ST_IDLE};
            ST_WAIT:     uw = '{OP_NONE, J_OUTBUSY, ST_WAIT};
            ST_EMIT:     uw = '{OP_EMIT, J_ALWAYS,  ST_IDLE};
            default:     uw = '{OP_NONE, J_ALWAYS,  ST_IDLE};
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

[rtl/bfa_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ram
// Single-port RAM, registered read; output holds when not reading.
// ----------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/bfa_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_seq
// Microprogram sequencer: step counter, control store, conditional jumps.
// ----------------------------------------------------------------------------
module bfa_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_req_free,
    input  wire bfa_pkg::t_stat i_stat,
    output bfa_pkg::t_ctrl     o_ctrl
);
    import bfa_pkg::*;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             take;

    always_comb begin
        uw = ucode(r_upc);
        case (uw.cond)
            J_NEXT:    take = 1'b0;
            J_ALWAYS:  take = 1'b1;
            J_NOIN:    take = !i_in_valid;
            J_FREE:    take = i_req_free;
            J_HIT:     take = i_stat.hit;
            J_MORE:    take = i_stat.more;
            J_NOCLR:   take = !i_stat.clr;
            J_OUTBUSY: take = i_stat.out_busy;
            default:   take = 1'b0;
        endcase
        n_upc       = take ? uw.target : r_upc + 1'b1;
        o_ctrl.op   = uw.op;
        o_ctrl.idle = (r_upc == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= ST_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    property p_accept_dispatch;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.idle && i_in_valid) |=> (r_upc == ST_DISPATCH);
    endproperty
    a_accept_dispatch: assert property (p_accept_dispatch)
        else $error("accepted beat did not reach dispatch");

    property p_emit_after_wait;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == ST_EMIT) |-> $past(r_upc) == ST_WAIT;
    endproperty
    a_emit_after_wait: assert property (p_emit_after_wait)
        else $error("emit step entered without wait step");

endmodule
`default_nettype wire

[rtl/bfa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_dp
// Datapath: pool registers, bitmap RAM with row valid bits, word scan,
// free decode and result register.
// ----------------------------------------------------------------------------
module bfa_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire bfa_pkg::t_ctrl                      i_ctrl,
    input  wire logic                                i_accept,
    input  wire logic                                i_req_type,
    input  wire logic [bfa_pkg::ADDR_W-1:0]          i_frame_addr,
    input  wire logic                                i_cfg_we,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bfa_pkg::ADDR_W-1:0]          i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_req_free,
    output bfa_pkg::t_stat                           o_stat,
    output logic                                     o_out_valid,
    output logic [bfa_pkg::ADDR_W-1:0]               o_alloc_addr,
    output logic                                     o_ok
);
    import bfa_pkg::*;

    logic [ADDR_W-1:0]     r_start;
    logic [ADDR_W-1:0]     r_end;
    logic                  r_req;
    logic [ADDR_W-1:0]     r_addr;
    logic [CNT_W-1:0]      r_nframes;
    logic [WORD_IDX_W-1:0] r_word;
    logic [BIT_W-1:0]      r_bit;
    logic [ADDR_W-1:0]     r_res_addr;
    logic                  r_res_ok;
    logic                  r_out_valid;
    logic [ADDR_W-1:0]     r_out_addr;
    logic                  r_out_ok;
    logic [N_WORDS-1:0]    r_row_valid;

    logic [WORD_W-1:0]     rdata;
    logic [WORD_W-1:0]     eff;
    logic [WORD_W-1:0]     mask;
    logic [WORD_W-1:0]     free_bits;
    logic [WORD_W-1:0]     low;
    logic [WORD_W-1:0]     bit_sel;
    logic [BIT_W-1:0]      low_idx;
    logic [HI_W-1:0]       wext;
    logic [HI_W-1:0]       w1;
    logic [ADDR_W-1:0]     diff;
    logic [ADDR_W-1:0]     pages;
    logic [CNT_W-1:0]      cnt;
    logic                  in_pool;
    logic [ADDR_W-1:0]     page;
    logic [ADDR_W-1:0]     pdiff;
    logic [ADDR_W-1:0]     pidx;
    logic                  clr;
    logic [ADDR_W-1:0]     a_addr;
    logic                  we;
    logic                  re;
    logic [WORD_W-1:0]     wdata;

    always_comb begin
        eff       = r_row_valid[r_word] ? rdata : '0;
        wext      = HI_W'(r_word);
        w1        = wext + 1'b1;
        if (wext < r_nframes[CNT_W-1:BIT_W]) begin
            mask = '1;
        end else if (wext == r_nframes[CNT_W-1:BIT_W]) begin
            mask = (WORD_W'(1) << r_nframes[BIT_W-1:0]) - 1'b1;
        end else begin
            mask = '0;
        end
        free_bits = ~eff & mask;
        low       = free_bits & (~free_bits + 1'b1);
        low_idx   = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (low[i]) begin
                low_idx = low_idx | BIT_W'(i);
            end
        end

        diff  = r_end - r_start;
        pages = diff >> FRAME_SHIFT;
        if (r_end <= r_start) begin
            cnt = '0;
        end else if (pages > ADDR_W'(MAX_FRAMES)) begin
            cnt = CNT_W'(MAX_FRAMES);
        end else begin
            cnt = CNT_W'(pages);
        end

        in_pool = (r_addr >= r_start) && (r_addr < r_end);
        page    = {r_addr[ADDR_W-1:FRAME_SHIFT], {FRAME_SHIFT{1'b0}}};
        pdiff   = page - r_start;
        pidx    = pdiff >> FRAME_SHIFT;
        clr     = in_pool && (page >= r_start) && (pidx < ADDR_W'(MAX_FRAMES));

        a_addr  = r_start + (ADDR_W'({r_word, r_bit}) << FRAME_SHIFT);

        bit_sel = WORD_W'(1) << r_bit;
        we      = (i_ctrl.op == OP_SET) || (i_ctrl.op == OP_CLR);
        re      = (i_ctrl.op == OP_READ);
        wdata   = (i_ctrl.op == OP_SET) ? (eff | bit_sel) : (eff & ~bit_sel);
    end

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (N_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_re    (re),
        .i_addr  (r_word),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL_START: r_start <= i_cfg_data;
                    CFG_POOL_END:   r_end   <= i_cfg_data;
                    default:        ;
                endcase
            end
            if (we) begin
                r_row_valid[r_word] <= 1'b1;
            end
            if (i_ctrl.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD: begin
                if (i_accept) begin
                    r_req     <= i_req_type;
                    r_addr    <= i_frame_addr;
                    r_nframes <= cnt;
                    r_word    <= '0;
                end
            end
            OP_SCAN: r_bit  <= low_idx;
            OP_NEXT: r_word <= r_word + 1'b1;
            OP_FAIL: begin
                r_res_addr <= '0;
                r_res_ok   <= 1'b0;
            end
            OP_SET: begin
                r_res_addr <= a_addr;
                r_res_ok   <= 1'b1;
            end
            OP_FCHK: begin
                r_res_addr <= '0;
                r_res_ok   <= in_pool;
                r_word     <= pidx[BIT_W +: WORD_IDX_W];
                r_bit      <= pidx[BIT_W-1:0];
            end
            OP_EMIT: begin
                r_out_addr <= r_res_addr;
                r_out_ok   <= r_res_ok;
            end
            default: ;
        endcase
    end

    assign o_req_free      = (r_req == REQ_FREE);
    assign o_stat.hit      = |free_bits;
    assign o_stat.more     = {w1, {BIT_W{1'b0}}} < r_nframes;
    assign o_stat.clr      = clr;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_alloc_addr    = r_out_addr;
    assign o_ok            = r_out_ok;

    property p_emit_free;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_EMIT) |-> !r_out_valid;
    endproperty
    a_emit_free: assert property (p_emit_free)
        else $error("result register overwritten before taken");

    property p_set_free_bit;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_SET) |-> !eff[r_bit];
    endproperty
    a_set_free_bit: assert property (p_set_free_bit)
        else $error("allocated frame already marked used");

    property p_clear_in_pool;
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_CLR) |-> r_res_ok;
    endproperty
    a_clear_in_pool: assert property (p_clear_in_pool)
        else $error("bit cleared for address outside pool");

endmodule
`default_nettype wire

[rtl/bitmap_frame_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit allocator of 4 KiB page frames over a bitmap of used bits.
//
// Slave channel: one beat per request; tuser is the request kind (0 alloc,
// 1 free), tdata the byte address to free. Master channel: one beat per
// request with the allocated address and an ok flag. Config channel writes
// pool_start (index 0) and pool_end (index 1); it is always ready and must
// be written by the user only while the block is idle (not enforced).
// A free checks the address against the pool, then reads the bitmap word
// and clears its bit; a free that maps to no bitmap frame changes no bit.
// An allocate scans one bitmap word at a time (up to 32 words, one RAM read
// per 32-bit word) and takes the first free frame, or fails when none is
// free. The next request can be taken in the cycle after the result is loaded.
// Reset clears the pool registers and marks every frame free through one
// valid bit per bitmap word; no clearing pass is needed.
// A result waits in the output register while the next request runs; the
// sequencer stalls before loading a new result until that one is taken.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [bfa_pkg::IN_TDATA_W-1:0]      i_s_tdata,  // [31:0] frame_addr
    input  wire logic                                i_s_tuser,  // [0] req_type
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [bfa_pkg::OUT_TDATA_W-1:0]          o_m_tdata,  // [31:0] alloc_addr, [32] ok
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bfa_pkg::ADDR_W-1:0]          i_cfg_data
);
    import bfa_pkg::*;

    t_ctrl             ctrl;
    t_stat             stat;
    logic              req_free;
    logic              accept;
    logic [ADDR_W-1:0] alloc_addr;
    logic              ok;

    assign o_s_tready  = ctrl.idle;
    assign accept      = i_s_tvalid && ctrl.idle;
    assign o_cfg_ready = 1'b1;
    assign o_m_tdata   = {{(OUT_TDATA_W - ADDR_W - 1){1'b0}}, ok, alloc_addr};

    bfa_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_req_free (req_free),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    bfa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_accept     (accept),
        .i_req_type   (i_s_tuser),
        .i_frame_addr (i_s_tdata[ADDR_W-1:0]),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_m_tready),
        .o_req_free   (req_free),
        .o_stat       (stat),
        .o_out_valid  (o_m_tvalid),
        .o_alloc_addr (alloc_addr),
        .o_ok         (ok)
    );

    property p_busy_after_accept;
        @(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("request accepted twice in a row");

endmodule
`default_nettype wire

[tb/bitmap_frame_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_tb
// Self-checking bench for the first-fit page frame allocator. A directed
// table covers the reset state, empty, inverted, unaligned and oversized
// pools, the frame at address zero and frees in and out of the pool. Random
// phases then reprogram the pool and mix allocate and free beats, with
// bursty stalls on both streams and one long output hold-off. Result beats
// are compared against the grant of fixed table rows or a bench frame pool.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_tb;
    import bfa_pkg::*;

    localparam int DIR_N          = 37;
    localparam int RAND_PHASES    = 11;
    localparam int BIG_PHASE      = 3;
    localparam int PRESSURE_PHASE = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 120;
    localparam logic [ADDR_W-1:0] TOP_PAGE = 32'hFFFF_F000;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              ok;
    } t_grant;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    // tag: register index for ROW_CFG, request kind for ROW_REQ
    typedef struct packed {
        t_row_kind         kind;
        logic              tag;
        logic [ADDR_W-1:0] val;
        logic              fixed;
        t_grant            want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;   // [31:0] frame_addr
    logic                   i_s_tuser;   // [0] req_type
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;   // [31:0] alloc_addr, [32] ok
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [ADDR_W-1:0]      i_cfg_data;

    logic [ADDR_W-1:0] pool_lo = '0;
    logic [ADDR_W-1:0] pool_hi = '0;
    logic              frame_taken [MAX_FRAMES];
    t_grant            grants_due [$];
    int                mismatches = 0;
    int                quiet_cycles = 0;
    int                src_gap_pct = 25;
    int                sink_gap_pct = 25;
    logic              hold_req = 1'b0;

    t_row dir_rows [DIR_N] = '{
        '{ROW_REQ, REQ_ALLOC,      32'hFFFF_FFFF, 1'b1, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'hFFFF_FFFF, 1'b1, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_START, 32'h0000_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_END,   32'h0000_3000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b1, '{32'h0,    1'b1}},
        '{ROW_REQ, REQ_ALLOC,      32'h5555_5555, 1'b1, '{32'h1000, 1'b1}},
        '{ROW_REQ, REQ_ALLOC,      32'hAAAA_AAAA, 1'b1, '{32'h2000, 1'b1}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b1, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'h0000_1FFF, 1'b1, '{32'h0,    1'b1}},
        '{ROW_REQ, REQ_FREE,       32'h0000_1FFF, 1'b1, '{32'h0,    1'b1}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b1, '{32'h1000, 1'b1}},
        '{ROW_REQ, REQ_FREE,       32'h0000_3000, 1'b1, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'h0000_0000, 1'b1, '{32'h0,    1'b1}},
        '{ROW_CFG, CFG_POOL_START, 32'h0001_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_END,   32'h0000_8000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b1, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'h0000_9000, 1'b1, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_START, 32'h0000_0123, 1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_END,   32'h0000_5123, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'h0000_0200, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'h0000_1200, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_START, 32'h0000_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_END,   TOP_PAGE,      1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'hFFFF_EFFF, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       TOP_PAGE,      1'b1, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_START, TOP_PAGE,      1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_END,   TOP_PAGE,      1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b1, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       TOP_PAGE,      1'b1, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_START, 32'hFFFF_E000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_CFG, CFG_POOL_END,   TOP_PAGE,      1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_ALLOC,      32'h0000_0000, 1'b0, '{32'h0,    1'b0}},
        '{ROW_REQ, REQ_FREE,       32'hFFFF_E800, 1'b0, '{32'h0,    1'b0}}
    };

    bitmap_frame_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        foreach (frame_taken[f]) frame_taken[f] = 1'b0;
    end

    // first-fit allocate, or release of the page holding addr
    function automatic t_grant take_or_release(input logic kind,
                                               input logic [ADDR_W-1:0] addr);
        t_grant            g;
        logic [ADDR_W-1:0] span;
        logic [ADDR_W-1:0] page;
        logic [ADDR_W-1:0] slot;
        g = '0;
        if (kind == REQ_ALLOC) begin
            span = (pool_hi <= pool_lo) ? '0 : (pool_hi - pool_lo) >> FRAME_SHIFT;
            if (span > MAX_FRAMES) span = MAX_FRAMES;
            for (int i = 0; i < span; i++) begin
                if (!g.ok && !frame_taken[i]) begin
                    frame_taken[i] = 1'b1;
                    g.addr = pool_lo + (i << FRAME_SHIFT);
                    g.ok = 1'b1;
                end
            end
        end else if (addr >= pool_lo && addr < pool_hi) begin
            g.ok = 1'b1;
            page = {addr[ADDR_W-1:FRAME_SHIFT], {FRAME_SHIFT{1'b0}}};
            if (page >= pool_lo) begin
                slot = (page - pool_lo) >> FRAME_SHIFT;
                if (slot < MAX_FRAMES) frame_taken[slot] = 1'b0;
            end
        end
        return g;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // i_cfg_valid is left high so back-to-back writes need no drop
    task automatic write_pool_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ADDR_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_POOL_START) pool_lo = val;
        else if (idx == CFG_POOL_END) pool_hi = val;
    endtask

    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr,
                                input logic fixed, input t_grant want);
        t_grant g;
        i_cfg_valid <= 1'b0;
        i_s_tvalid  <= 1'b1;
        i_s_tuser   <= kind;
        i_s_tdata   <= addr;
        do @(posedge i_clk); while (!o_s_tready);
        g = take_or_release(kind, addr);
        grants_due.push_back(fixed ? want : g);
        if ($urandom_range(0, 99) < src_gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // result sink: random stall bursts plus one long hold-off on request
    initial begin
        logic hold_done;
        hold_done = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < sink_gap_pct) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (grants_due.size() == 0) begin
                flag_mismatch($sformatf("result beat %h with nothing pending", o_m_tdata));
            end else begin
                want = grants_due.pop_front();
                if (o_m_tdata[ADDR_W-1:0] !== want.addr)
                    flag_mismatch($sformatf("alloc_addr %h, want %h",
                                            o_m_tdata[ADDR_W-1:0], want.addr));
                if (o_m_tdata[ADDR_W] !== want.ok)
                    flag_mismatch($sformatf("ok %b, want %b", o_m_tdata[ADDR_W], want.ok));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmap_frame_allocator_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [ADDR_W-1:0] p_start;
        logic [ADDR_W-1:0] p_end;
        logic [ADDR_W-1:0] addr;
        longint unsigned   end_wide;
        int unsigned       span;
        int unsigned       alloc_pct;
        int unsigned       n_items;
        int unsigned       sel;
        logic              kind;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_pool_reg(dir_rows[r].tag, dir_rows[r].val);
            else
                send_request(dir_rows[r].tag, dir_rows[r].val, dir_rows[r].fixed,
                             dir_rows[r].want);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            sel = $urandom_range(0, 9);
            if (ph == BIG_PHASE) begin
                // beyond the bitmap depth, allocate-heavy to push the scan deep
                p_start   = {20'($urandom_range(0, 20'hFFBF9)), 12'h000};
                p_end     = p_start + (1030 << FRAME_SHIFT);
                alloc_pct = 90;
                n_items   = 90;
            end else begin
                p_start = (sel < 2) ? '0 : {20'($urandom_range(0, 20'hFFFFF)), 12'h000};
                if (sel == 2) p_start = $urandom_range(0, TOP_PAGE);
                end_wide = longint'(p_start) + ($urandom_range(1, 40) << FRAME_SHIFT);
                if (end_wide > TOP_PAGE) end_wide = TOP_PAGE;
                p_end = end_wide[ADDR_W-1:0];
                if (sel == 3) p_end = $urandom_range(0, p_start);
                alloc_pct = $urandom_range(35, 70);
                n_items   = 36;
            end
            write_pool_reg(CFG_POOL_START, p_start);
            write_pool_reg(CFG_POOL_END, p_end);

            span = (p_end <= p_start) ? 0 : (p_end - p_start) >> FRAME_SHIFT;
            if (span > MAX_FRAMES) span = MAX_FRAMES;
            case ($urandom_range(0, 2))
                0: begin src_gap_pct = 0;  sink_gap_pct = 10; end
                1: begin src_gap_pct = 20; sink_gap_pct = 0;  end
                default: begin src_gap_pct = 30; sink_gap_pct = 30; end
            endcase
            if (ph == RAND_PHASES - 1) begin
                src_gap_pct  = 0;
                sink_gap_pct = 0;
            end
            if (ph == PRESSURE_PHASE) hold_req <= 1'b1;

            repeat (n_items) begin
                kind = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_FREE;
                addr = $urandom;
                if (kind == REQ_FREE) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: begin
                            if (span > 0)
                                addr = p_start + ($urandom_range(0, span - 1) << FRAME_SHIFT)
                                       + $urandom_range(0, 4095);
                        end
                        6: addr = p_start - 1;
                        7: addr = p_start;
                        8: addr = $urandom_range(0, 1) ? p_end : p_end - 1;
                        default: addr = $urandom;
                    endcase
                end
                send_request(kind, addr, 1'b0, '0);
            end
        end

        i_s_tvalid <= 1'b0;
        while (grants_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("bitmap_frame_allocator_tb: clean");
        end else begin
            $display("bitmap_frame_allocator_tb: errors");
        end
        $finish;
    end

endmodule
